// ===== design/tra_pkg.sv =====
package tra_pkg;

    localparam int CHANNELS    = 32;
    localparam int CH_W        = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int ABN_PROD_W  = 25;
    localparam int CNF_PROD_W  = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ABNORMAL_RATE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_RATE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_ROUND  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS_PER_WINDOW = 3'd5;

    localparam logic [14:0] RST_LEVEL_THRESHOLD   = 15'd60;
    localparam logic [8:0]  RST_ABNORMAL_RATE     = 9'd128;
    localparam logic [8:0]  RST_CONFIRM_RATE      = 9'd51;
    localparam logic [5:0]  RST_NUM_CHANNELS      = 6'd32;
    localparam logic [15:0] RST_FRAMES_PER_ROUND  = 16'd500;
    localparam logic [7:0]  RST_ROUNDS_PER_WINDOW = 8'd5;

    typedef struct packed {
        logic [14:0]           level_threshold;
        logic [5:0]            nch_eff;
        logic [15:0]           fpr_eff;
        logic [7:0]            rpw_eff;
        logic [ABN_PROD_W-1:0] abn_prod;
        logic [CNF_PROD_W-1:0] cnf_prod;
    } t_cfg;

    typedef struct packed {
        logic [CH_W-1:0]    chan;
        logic signed [15:0] sample;
        logic               abnormal;
        logic               last_chan;
        logic               last_frame;
        logic               last_round;
    } t_item;

endpackage

// ===== design/tra_cfg.sv =====
module tra_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [tra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tra_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_cfg_ready,
    output tra_pkg::t_cfg                  o_cfg
);
    import tra_pkg::*;

    logic [14:0]           r_level_threshold;
    logic [8:0]            r_abnormal_rate;
    logic [8:0]            r_confirm_rate;
    logic [5:0]            r_num_channels;
    logic [15:0]           r_frames_per_round;
    logic [7:0]            r_rounds_per_window;
    logic [ABN_PROD_W-1:0] r_abn_prod;
    logic [CNF_PROD_W-1:0] r_cnf_prod;
    logic [5:0]            w_nch_eff;
    logic [15:0]           w_fpr_eff;
    logic [7:0]            w_rpw_eff;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_num_channels == 6'd0) begin
            w_nch_eff = 6'd1;
        end else if (r_num_channels > 6'(CHANNELS)) begin
            w_nch_eff = 6'(CHANNELS);
        end else begin
            w_nch_eff = r_num_channels;
        end
        w_fpr_eff = (r_frames_per_round == 16'd0) ? 16'd1 : r_frames_per_round;
        w_rpw_eff = (r_rounds_per_window == 8'd0) ? 8'd1 : r_rounds_per_window;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_threshold   <= RST_LEVEL_THRESHOLD;
            r_abnormal_rate     <= RST_ABNORMAL_RATE;
            r_confirm_rate      <= RST_CONFIRM_RATE;
            r_num_channels      <= RST_NUM_CHANNELS;
            r_frames_per_round  <= RST_FRAMES_PER_ROUND;
            r_rounds_per_window <= RST_ROUNDS_PER_WINDOW;
            r_abn_prod          <= ABN_PROD_W'(RST_ABNORMAL_RATE) *
                                   ABN_PROD_W'(RST_FRAMES_PER_ROUND);
            r_cnf_prod          <= CNF_PROD_W'(RST_CONFIRM_RATE) *
                                   CNF_PROD_W'(RST_ROUNDS_PER_WINDOW);
        end else begin
            r_abn_prod <= ABN_PROD_W'(r_abnormal_rate) * ABN_PROD_W'(w_fpr_eff);
            r_cnf_prod <= CNF_PROD_W'(r_confirm_rate) * CNF_PROD_W'(w_rpw_eff);
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LEVEL_THRESHOLD:   r_level_threshold   <= i_cfg_data[14:0];
                    CFG_ABNORMAL_RATE:     r_abnormal_rate     <= i_cfg_data[8:0];
                    CFG_CONFIRM_RATE:      r_confirm_rate      <= i_cfg_data[8:0];
                    CFG_NUM_CHANNELS:      r_num_channels      <= i_cfg_data[5:0];
                    CFG_FRAMES_PER_ROUND:  r_frames_per_round  <= i_cfg_data[15:0];
                    CFG_ROUNDS_PER_WINDOW: r_rounds_per_window <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        o_cfg.level_threshold = r_level_threshold;
        o_cfg.nch_eff         = w_nch_eff;
        o_cfg.fpr_eff         = w_fpr_eff;
        o_cfg.rpw_eff         = w_rpw_eff;
        o_cfg.abn_prod        = r_abn_prod;
        o_cfg.cnf_prod        = r_cnf_prod;
    end

endmodule

// ===== design/tra_front.sv =====
module tra_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tra_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    input  logic signed [15:0] i_sample,
    output logic               o_in_stall,
    input  logic               i_queue_full,
    output logic               o_push,
    output tra_pkg::t_item     o_item
);
    import tra_pkg::*;

    logic [CH_W-1:0] r_chan_pos;
    logic [15:0]     r_frame_pos;
    logic [7:0]      r_round_pos;
    logic [15:0]     w_mag;
    logic            w_last_chan;
    logic            w_last_frame;
    logic            w_last_round;

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !o_in_stall;

    always_comb begin
        w_mag        = i_sample[15] ? 16'(-i_sample) : 16'(i_sample);
        w_last_chan  = (6'(r_chan_pos) + 6'd1) >= i_cfg.nch_eff;
        w_last_frame = (17'(r_frame_pos) + 17'd1) >= 17'(i_cfg.fpr_eff);
        w_last_round = (9'(r_round_pos) + 9'd1) >= 9'(i_cfg.rpw_eff);

        o_item.chan       = r_chan_pos;
        o_item.sample     = i_sample;
        o_item.abnormal   = w_mag >= 16'(i_cfg.level_threshold);
        o_item.last_chan  = w_last_chan;
        o_item.last_frame = w_last_frame;
        o_item.last_round = w_last_round;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_pos  <= '0;
            r_frame_pos <= '0;
            r_round_pos <= '0;
        end else if (o_push) begin
            if (w_last_chan) begin
                r_chan_pos <= '0;
                if (w_last_frame) begin
                    r_frame_pos <= '0;
                    r_round_pos <= w_last_round ? 8'd0 : r_round_pos + 8'd1;
                end else begin
                    r_frame_pos <= r_frame_pos + 16'd1;
                end
            end else begin
                r_chan_pos <= r_chan_pos + CH_W'(1);
            end
        end
    end

endmodule

// ===== design/tra_queue.sv =====
module tra_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tra_pkg::t_item i_item,
    input  logic           i_pop,
    output tra_pkg::t_item o_item,
    output logic           o_empty,
    output logic           o_full
);
    import tra_pkg::*;

    t_item           r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wr_ptr;
    logic [QA_W-1:0] r_rd_ptr;
    logic [QA_W:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QA_W+1)'(QUEUE_DEPTH));
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QA_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QA_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QA_W+1)'(1);
                2'b01:   r_count <= r_count - (QA_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/tra_back.sv =====
module tra_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tra_pkg::t_cfg             i_cfg,
    input  tra_pkg::t_item            i_item,
    input  logic                      i_empty,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [tra_pkg::CH_W-1:0]  o_channel,
    output logic                      o_alarm,
    output logic signed [15:0]        o_peak,
    output logic                      o_last
);
    import tra_pkg::*;

    logic signed [15:0] r_peak [CHANNELS];
    logic [15:0]        r_over [CHANNELS];
    logic [7:0]         r_pass [CHANNELS];

    logic               r_out_valid;
    logic [CH_W-1:0]    r_channel;
    logic               r_alarm;
    logic signed [15:0] r_out_peak;
    logic               r_last;

    logic [CH_W-1:0]    w_c;
    logic signed [15:0] w_peak_new;
    logic [15:0]        w_over_new;
    logic               w_round_pass;
    logic [7:0]         w_pass_new;
    logic               w_alarm;
    logic               w_emit;

    assign o_pop = !i_empty && (!r_out_valid || !i_out_stall);

    always_comb begin
        w_c          = i_item.chan;
        w_peak_new   = ($signed(i_item.sample) > r_peak[w_c]) ? $signed(i_item.sample)
                                                               : r_peak[w_c];
        w_over_new   = r_over[w_c] +
                       16'(i_item.abnormal && (r_over[w_c] != 16'hFFFF));
        w_round_pass = {1'b0, w_over_new, 8'h00} >= i_cfg.abn_prod;
        w_pass_new   = r_pass[w_c] + 8'(w_round_pass && (r_pass[w_c] != 8'hFF));
        w_alarm      = {1'b0, w_pass_new, 8'h00} >= i_cfg.cnf_prod;
        w_emit       = i_item.last_frame && i_item.last_round;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_peak[i] <= '0;
                r_over[i] <= '0;
                r_pass[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_peak[w_c] <= w_peak_new;
                r_over[w_c] <= i_item.last_frame ? 16'd0 : w_over_new;
                if (i_item.last_frame) begin
                    r_pass[w_c] <= i_item.last_round ? 8'd0 : w_pass_new;
                end
            end
            if (o_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_channel  <= w_c;
            r_alarm    <= w_alarm;
            r_out_peak <= w_peak_new;
            r_last     <= i_item.last_chan;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_channel   = r_channel;
    assign o_alarm     = r_alarm;
    assign o_peak      = r_out_peak;
    assign o_last      = r_last;

    a_window_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_emit) |=> o_out_valid)
        else $error("window end word not presented");

    a_round_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.last_frame) |=> (r_over[$past(w_c)] == 16'd0))
        else $error("over count not cleared at round end");

    a_peak_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_peak[$past(w_c)] >= $past(r_peak[w_c])))
        else $error("channel peak decreased");

endmodule

// ===== design/threshold_rate_alarm.sv =====
// Path: accepted samples pass through the queue to the back end; a window's last
// sample registers its verdict word, held on the outputs while the output is stalled.
// Throughput: one sample per cycle unless stalled, set by a single read-modify-write
// of the per-channel counters in the back end; a four-word queue separates front and
// back. Reset: synchronous, active low; clears positions, counters and peaks at once
// and restores register defaults; the configuration port is always ready.
module threshold_rate_alarm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tra_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [15:0]             i_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tra_pkg::CH_W-1:0]       o_channel,
    output logic                           o_alarm,
    output logic signed [15:0]             o_peak,
    output logic                           o_last
);
    import tra_pkg::*;

    t_cfg  w_cfg;
    t_item w_push_item;
    t_item w_pop_item;
    logic  w_push;
    logic  w_pop;
    logic  w_empty;
    logic  w_full;

    tra_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    tra_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_in_valid   (i_in_valid),
        .i_sample     (i_sample),
        .o_in_stall   (o_in_stall),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    tra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_pop_item),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    tra_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_item      (w_pop_item),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_channel   (o_channel),
        .o_alarm     (o_alarm),
        .o_peak      (o_peak),
        .o_last      (o_last)
    );

endmodule

// ===== sim/tra_verdict_checker.sv =====
`timescale 1ns / 100ps

module tra_verdict_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [tra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tra_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic signed [15:0]             i_sample,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [tra_pkg::CH_W-1:0]       i_channel,
    input  logic                           i_alarm,
    input  logic signed [15:0]             i_peak,
    input  logic                           i_last,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef struct packed {
        logic [tra_pkg::CH_W-1:0] channel;
        logic                     alarm;
        logic signed [15:0]       peak;
        logic                     last;
    } t_verdict;

    logic [14:0]        level_thr;
    logic [8:0]         abn_rate;
    logic [8:0]         cnf_rate;
    logic [5:0]         chan_cfg;
    logic [15:0]        frames_cfg;
    logic [7:0]         rounds_cfg;

    logic [4:0]         chan_at;
    logic [15:0]        frame_at;
    logic [7:0]         round_at;
    logic [15:0]        over_cnt [tra_pkg::CHANNELS];
    logic [7:0]         pass_cnt [tra_pkg::CHANNELS];
    logic signed [15:0] peak_val [tra_pkg::CHANNELS];

    t_verdict verdict_q[$];
    int       fails     = 0;
    int       pending_r = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending_r;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        fails++;
    endtask

    task automatic clear_model();
        level_thr  = tra_pkg::RST_LEVEL_THRESHOLD;
        abn_rate   = tra_pkg::RST_ABNORMAL_RATE;
        cnf_rate   = tra_pkg::RST_CONFIRM_RATE;
        chan_cfg   = tra_pkg::RST_NUM_CHANNELS;
        frames_cfg = tra_pkg::RST_FRAMES_PER_ROUND;
        rounds_cfg = tra_pkg::RST_ROUNDS_PER_WINDOW;
        chan_at    = '0;
        frame_at   = '0;
        round_at   = '0;
        foreach (over_cnt[i]) begin
            over_cnt[i] = '0;
            pass_cnt[i] = '0;
            peak_val[i] = '0;
        end
        verdict_q.delete();
    endtask

    task automatic load_register(input logic [tra_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [tra_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            tra_pkg::CFG_LEVEL_THRESHOLD:   level_thr  = data[14:0];
            tra_pkg::CFG_ABNORMAL_RATE:     abn_rate   = data[8:0];
            tra_pkg::CFG_CONFIRM_RATE:      cnf_rate   = data[8:0];
            tra_pkg::CFG_NUM_CHANNELS:      chan_cfg   = data[5:0];
            tra_pkg::CFG_FRAMES_PER_ROUND:  frames_cfg = data[15:0];
            tra_pkg::CFG_ROUNDS_PER_WINDOW: rounds_cfg = data[7:0];
            default: ;
        endcase
    endtask

    task automatic tally_sample(input logic signed [15:0] s);
        int       nch;
        int       fpr;
        int       rpw;
        int       mag;
        int       ch;
        bit       last_chan;
        bit       last_frame;
        bit       last_round;
        t_verdict v;

        nch = (chan_cfg == 0) ? 1 : int'(chan_cfg);
        if (nch > tra_pkg::CHANNELS) nch = tra_pkg::CHANNELS;
        fpr = (frames_cfg == 0) ? 1 : int'(frames_cfg);
        rpw = (rounds_cfg == 0) ? 1 : int'(rounds_cfg);
        mag = (s < 0) ? -int'(s) : int'(s);
        ch  = int'(chan_at);
        last_chan  = int'(chan_at) + 1 >= nch;
        last_frame = int'(frame_at) + 1 >= fpr;
        last_round = int'(round_at) + 1 >= rpw;

        if (s > peak_val[ch]) peak_val[ch] = s;
        if (mag >= int'(level_thr) && over_cnt[ch] != 16'hFFFF) over_cnt[ch]++;

        if (last_frame) begin
            if (int'(over_cnt[ch]) * 256 >= int'(abn_rate) * fpr && pass_cnt[ch] != 8'hFF) begin
                pass_cnt[ch]++;
            end
            over_cnt[ch] = '0;
            if (last_round) begin
                v.channel = chan_at;
                v.alarm   = int'(pass_cnt[ch]) * 256 >= int'(cnf_rate) * rpw;
                v.peak    = peak_val[ch];
                v.last    = last_chan;
                verdict_q.push_back(v);
                pass_cnt[ch] = '0;
            end
        end

        if (last_chan) begin
            chan_at = '0;
            if (last_frame) begin
                frame_at = '0;
                round_at = last_round ? 8'd0 : round_at + 8'd1;
            end else begin
                frame_at++;
            end
        end else begin
            chan_at++;
        end
    endtask

    task automatic check_verdict();
        t_verdict want;
        if (verdict_q.size() == 0) begin
            report_mismatch($sformatf("unexpected verdict word for channel %0d", i_channel));
        end else begin
            want = verdict_q.pop_front();
            if (i_channel !== want.channel)
                report_mismatch($sformatf("channel %0d, want %0d", i_channel, want.channel));
            if (i_alarm !== want.alarm)
                report_mismatch($sformatf("alarm %b, want %b on channel %0d",
                                          i_alarm, want.alarm, want.channel));
            if (i_peak !== want.peak)
                report_mismatch($sformatf("peak %0d, want %0d on channel %0d",
                                          i_peak, want.peak, want.channel));
            if (i_last !== want.last)
                report_mismatch($sformatf("last %b, want %b on channel %0d",
                                          i_last, want.last, want.channel));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_out_valid && !i_out_stall) check_verdict();
            if (i_cfg_valid && i_cfg_ready) load_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && !i_in_stall) tally_sample(i_sample);
        end
        pending_r <= verdict_q.size();
    end

endmodule

// ===== sim/threshold_rate_alarm_tb.sv =====
`timescale 1ns / 100ps

module threshold_rate_alarm_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES       = 12;
    localparam int PHASE_WORDS  = 58;

    localparam logic [tra_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [tra_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tra_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tra_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    logic signed [15:0]             in_sample = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [tra_pkg::CH_W-1:0]       channel;
    logic                           alarm;
    logic signed [15:0]             peak;
    logic                           last;

    int fail_count;
    int pending;
    int cycle_cnt    = 0;
    int idle_in_pct  = 0;
    int idle_out_pct = 0;
    int hold_left    = 0;
    int cur_thr      = 60;
    int abn_pct      = 50;

    threshold_rate_alarm i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_sample    (in_sample),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_channel   (channel),
        .o_alarm     (alarm),
        .o_peak      (peak),
        .o_last      (last)
    );

    tra_verdict_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_sample     (in_sample),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_channel    (channel),
        .i_alarm      (alarm),
        .i_peak       (peak),
        .i_last       (last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // hold off for a counted stretch when asked, else stall at random
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < idle_out_pct);
            end
        end
    end

    function automatic logic [15:0] with_junk(input int value, input int width);
        logic [15:0] w;
        w = 16'(value);
        if (width < 16 && $urandom_range(1) == 1) w = w | (16'($urandom()) << width);
        return w;
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(4))
            0:       return 0;
            1:       return 256;
            2:       return $urandom_range(511, 257);
            default: return $urandom_range(256);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_sample();
        int mag;
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 16'($urandom());
        if (pick == 1) begin
            case ($urandom_range(3))
                0:       return 16'sh8000;
                1:       return 16'sh7FFF;
                2:       return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        if (pick == 2) begin
            mag = cur_thr - $urandom_range(1);
            if (mag < 0) mag = 0;
        end else if (cur_thr == 0 || $urandom_range(99) < abn_pct) begin
            mag = $urandom_range(32768, cur_thr);
        end else begin
            mag = $urandom_range(cur_thr - 1, 0);
        end
        if (mag >= 32768) return 16'sh8000;
        if ($urandom_range(1) == 1) return 16'(-mag);
        return 16'(mag);
    endfunction

    task automatic write_reg(input logic [tra_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tra_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic setup(input int thr, input int abn, input int cnf,
                         input int nch, input int fpr, input int rpw);
        write_reg(tra_pkg::CFG_LEVEL_THRESHOLD,   with_junk(thr, 15));
        write_reg(tra_pkg::CFG_ABNORMAL_RATE,     with_junk(abn, 9));
        write_reg(tra_pkg::CFG_CONFIRM_RATE,      with_junk(cnf, 9));
        write_reg(tra_pkg::CFG_NUM_CHANNELS,      with_junk(nch, 6));
        write_reg(tra_pkg::CFG_FRAMES_PER_ROUND,  with_junk(fpr, 16));
        write_reg(tra_pkg::CFG_ROUNDS_PER_WINDOW, with_junk(rpw, 8));
        if ($urandom_range(2) == 0) begin
            write_reg($urandom_range(1) == 1 ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom()));
        end
        cfg_valid <= 1'b0;
        cur_thr = thr;
    endtask

    task automatic random_setup();
        int thr;
        int nch;
        case ($urandom_range(3))
            0:       thr = 0;
            1:       thr = 32767;
            2:       thr = $urandom_range(32767);
            default: thr = $urandom_range(300);
        endcase
        case ($urandom_range(5))
            0:       nch = 0;
            1:       nch = 1;
            2:       nch = 32;
            3:       nch = $urandom_range(63, 33);
            default: nch = $urandom_range(8, 1);
        endcase
        setup(thr, pick_rate(), pick_rate(), nch, $urandom_range(3), $urandom_range(3));
        abn_pct = $urandom_range(100);
    endtask

    task automatic send_sample(input logic signed [15:0] s);
        while ($urandom_range(99) < idle_in_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_sample <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_in_pct  = 20;
        idle_out_pct = 20;

        // zero counts and lengths act as one, every sample abnormal
        setup(0, 0, 0, 0, 0, 0);
        send_sample(16'sh0000);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'shFFFF);
        send_sample(16'sd100);
        drain();

        // top threshold and full rates
        setup(32767, 256, 256, 2, 1, 1);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFE);
        send_sample(-16'sd32767);
        drain();

        // rates above 256 never met, rate zero always met
        setup(5, 257, 0, 1, 1, 1);
        send_sample(16'sd5);
        send_sample(-16'sd5);
        drain();
        write_reg(tra_pkg::CFG_ABNORMAL_RATE, 16'd0);
        write_reg(tra_pkg::CFG_CONFIRM_RATE, 16'd511);
        cfg_valid <= 1'b0;
        send_sample(-16'sd4);
        drain();

        // long lengths, then shrink them under the running positions
        setup(100, 128, 128, 3, 65535, 255);
        repeat (7) send_sample(pick_sample());
        drain();
        write_reg(tra_pkg::CFG_NUM_CHANNELS, 16'd1);
        write_reg(tra_pkg::CFG_FRAMES_PER_ROUND, 16'd1);
        cfg_valid <= 1'b0;
        repeat (3) send_sample(pick_sample());
        drain();
        write_reg(tra_pkg::CFG_ROUNDS_PER_WINDOW, 16'd2);
        cfg_valid <= 1'b0;
        send_sample(16'sd200);
        send_sample(-16'sd300);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph / 4)
                0: begin
                    idle_in_pct  = 9;
                    idle_out_pct = 81;
                end
                1: begin
                    idle_in_pct  = 81;
                    idle_out_pct = 9;
                end
                default: begin
                    idle_in_pct  = 0;
                    idle_out_pct = 0;
                end
            endcase
            random_setup();
            repeat (PHASE_WORDS) send_sample(pick_sample());
            drain();
        end

        // hold the output side while words keep coming, so the input stalls
        idle_in_pct  = 0;
        idle_out_pct = 0;
        setup(50, 128, 128, 4, 1, 1);
        abn_pct   = 50;
        hold_left = 300;
        repeat (40) send_sample(pick_sample());
        drain();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
